// ----- rtl/core/gpf_pkg.sv -----
// shared constants, tables and types for the globular projection pipeline
`default_nettype none

package gpf_pkg;

   localparam int FRAC_BITS   = 29;
   localparam int SINE_TERMS  = 8;
   localparam int SQRT_STEPS  = 33;
   localparam int DIV_STEPS   = 32;

   // pi, pi/2 and (pi/2)^2, rounded to the fraction grid
   localparam logic [31:0] PI_Q   = 32'd1686629713;
   localparam logic [29:0] HALF_Q = 30'd843314857;
   localparam logic [30:0] HSQ_Q  = 31'd1324675879;
   localparam logic [29:0] ONE_Q  = 30'(64'd1 << FRAC_BITS);

   // csr register indexes
   localparam logic [1:0] CSR_SINE_LATITUDE = 2'd0;
   localparam logic [1:0] CSR_OVAL_OUTER    = 2'd1;

   // horner divisors (2k)(2k+1) for k = 8 down to 1, and their floored 2^32 reciprocals
   localparam logic [8:0] SINE_DIV [SINE_TERMS] = '{
      9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
   };
   localparam logic [31:0] SINE_RECIP [SINE_TERMS] = '{
      32'(64'h1_0000_0000 / 272), 32'(64'h1_0000_0000 / 210),
      32'(64'h1_0000_0000 / 156), 32'(64'h1_0000_0000 / 110),
      32'(64'h1_0000_0000 / 72),  32'(64'h1_0000_0000 / 42),
      32'(64'h1_0000_0000 / 20),  32'(64'h1_0000_0000 / 6)
   };

   // per-point sideband that rides along the cell chains
   typedef struct packed {
      logic [30:0] a;        // |longitude|
      logic [29:0] p;        // |latitude|
      logic [29:0] v;        // |y|
      logic        lon_neg;
      logic        lat_neg;
      logic        sine;
      logic        oval;     // arc formula applies to this point
      logic [33:0] g;        // bulge base, later the divisor
      logic [62:0] nq;       // bulge numerator
      logic [32:0] root;
   } gpf_item_type;

endpackage

`default_nettype wire

// ----- rtl/core/gpf_if.sv -----
// valid/ready channel interfaces for request, response and csr writes
`default_nettype none

interface gpf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] longitude;
   logic signed [30:0] latitude;
   modport source (output valid, output longitude, output latitude, input ready);
   modport sink   (input valid, input longitude, input latitude, output ready);
endinterface

interface gpf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] plane_x;
   logic signed [30:0] plane_y;
   modport source (output valid, output plane_x, output plane_y, input ready);
   modport sink   (input valid, input plane_x, input plane_y, output ready);
endinterface

interface gpf_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [0:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gpf_sine_cell.sv -----
// one horner step of the sine series: t = one - z*t / divisor, three stages
`default_nettype none

module gpf_sine_cell import gpf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire logic [30:0]  in_z,
   input  wire logic [29:0]  in_t,
   input  wire gpf_item_type in_item,
   input  wire logic [8:0]   div_k,
   input  wire logic [31:0]  recip_k,
   output logic              out_valid,
   output logic [30:0]       out_z,
   output logic [29:0]       out_t,
   output gpf_item_type      out_item
);

   logic         v1_ff, v2_ff, v3_ff;
   logic [30:0]  z1_ff, z2_ff, z3_ff;
   gpf_item_type item1_ff, item2_ff, item3_ff;
   logic [30:0]  w1_ff, w1_in, w2_ff;
   logic [30:0]  q0_ff, q0_in;
   logic [29:0]  t_ff, t_in;

   logic [60:0]  zt_prod;
   logic [62:0]  wm_prod;
   logic [39:0]  qd_prod;
   logic [30:0]  rem;
   logic [30:0]  q_fix;

   // z*t rescaled
   assign zt_prod = in_z * in_t;
   assign w1_in   = zt_prod[FRAC_BITS+30:FRAC_BITS];

   // reciprocal estimate, at most one short
   assign wm_prod = w1_ff * recip_k;
   assign q0_in   = wm_prod[62:32];

   // correct the estimate and close the step
   assign qd_prod = q0_ff * div_k;
   assign rem     = w2_ff - qd_prod[30:0];
   assign q_fix   = (rem >= {22'd0, div_k}) ? q0_ff + 31'd1 : q0_ff;
   assign t_in    = ONE_Q - q_fix[29:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z1_ff    <= in_z;
         z2_ff    <= z1_ff;
         z3_ff    <= z2_ff;
         item1_ff <= in_item;
         item2_ff <= item1_ff;
         item3_ff <= item2_ff;
         w1_ff    <= w1_in;
         w2_ff    <= w1_ff;
         q0_ff    <= q0_in;
         t_ff     <= t_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_z     = z3_ff;
   assign out_t     = t_ff;
   assign out_item  = item3_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gpf_sqrt_cell.sv -----
// one restoring square root step: two radicand bits in, one root bit out
`default_nettype none

module gpf_sqrt_cell import gpf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire logic [65:0]  in_rad,
   input  wire logic [34:0]  in_rem,
   input  wire logic [32:0]  in_root,
   input  wire gpf_item_type in_item,
   output logic              out_valid,
   output logic [65:0]       out_rad,
   output logic [34:0]       out_rem,
   output logic [32:0]       out_root,
   output gpf_item_type      out_item
);

   logic         valid_ff;
   logic [65:0]  rad_ff, rad_in;
   logic [34:0]  rem_ff, rem_in;
   logic [32:0]  root_ff, root_in;
   gpf_item_type item_ff;

   logic [36:0]  rin;
   logic [36:0]  trial;
   logic [36:0]  diff;
   logic         ge;

   assign rin     = {in_rem, in_rad[65:64]};
   assign trial   = {2'b00, in_root, 2'b01};
   assign diff    = rin - trial;
   assign ge      = (rin >= trial);
   assign rem_in  = ge ? diff[34:0] : rin[34:0];
   assign root_in = {in_root[31:0], ge};
   assign rad_in  = {in_rad[63:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gpf_div_cell.sv -----
// one restoring division step against the divisor carried in the item
`default_nettype none

module gpf_div_cell import gpf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire logic [33:0]  in_rem,
   input  wire logic [31:0]  in_num,
   input  wire logic [31:0]  in_quo,
   input  wire gpf_item_type in_item,
   output logic              out_valid,
   output logic [33:0]       out_rem,
   output logic [31:0]       out_num,
   output logic [31:0]       out_quo,
   output gpf_item_type      out_item
);

   logic         valid_ff;
   logic [33:0]  rem_ff, rem_in;
   logic [31:0]  num_ff, num_in;
   logic [31:0]  quo_ff, quo_in;
   gpf_item_type item_ff;

   logic [34:0]  rin;
   logic [34:0]  dv;
   logic [34:0]  diff;
   logic         ge;

   assign rin    = {in_rem, in_num[31]};
   assign dv     = {1'b0, in_item.g};
   assign diff   = rin - dv;
   assign ge     = (rin >= dv);
   assign rem_in = ge ? diff[33:0] : rin[33:0];
   assign quo_in = {in_quo[30:0], ge};
   assign num_in = {in_num[30:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         quo_ff  <= quo_in;
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_quo   = quo_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ----- rtl/core/globular_projection_forward.sv -----
// Globular projection, forward: lon/lat points (longitude Q2.29, latitude Q1.29 radians) to
// plane x/y. The block is a pipeline that takes one request per clock while the chain is not
// paused and returns one response per request, in order. Every point walks the same chain of
// cells: eight three-stage horner cells for the Bacon sine, a few multiply stages that build the
// bulge terms, 33 square root cells (one root bit each) and 32 divide cells (one quotient bit
// each). Throughput is one point per cycle while not paused, set by the one-step-per-cell
// chains. A two-entry output buffer sits between the chain and the response port, so the chain
// keeps taking requests while a finished result waits; when both entries are held the whole
// chain pauses and req_bus.ready drops. The csr port takes a write every cycle; write only while
// the pipeline is empty. Register 0 selects Bacon northing, register 1 the Ortelius arc.
`default_nettype none

module globular_projection_forward import gpf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   gpf_req_if.sink   req_bus,
   gpf_rsp_if.source rsp_bus,
   gpf_csr_if.sink   csr_bus
);

   // ---------------------------------------------------------------- csr registers
   logic sine_latitude_ff, sine_latitude_in;
   logic oval_outer_ff, oval_outer_in;
   logic csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      sine_latitude_in = sine_latitude_ff;
      oval_outer_in    = oval_outer_ff;
      if (csr_write) begin
         unique case (csr_bus.index)
            CSR_SINE_LATITUDE: begin
               sine_latitude_in = csr_bus.data[0];
            end
            CSR_OVAL_OUTER: begin
               oval_outer_in = csr_bus.data[0];
            end
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_latitude_ff <= 1'b0;
         oval_outer_ff    <= 1'b0;
      end else begin
         sine_latitude_ff <= sine_latitude_in;
         oval_outer_ff    <= oval_outer_in;
      end
   end

   // ---------------------------------------------------------------- flow control
   logic [1:0] count_ff, count_in;
   logic       en;

   // the chain moves as one; it pauses only while the output buffer is full
   assign en            = (count_ff != 2'd2);
   assign req_bus.ready = en;

   // ---------------------------------------------------------------- stage 0: saturate, fold sign
   logic [31:0]  lon_abs;
   logic [30:0]  lat_abs;
   gpf_item_type item0_ff, item0_in;
   logic         v0_ff;

   assign lon_abs = req_bus.longitude[31] ? (~req_bus.longitude + 32'd1)
                                          : req_bus.longitude;
   assign lat_abs = req_bus.latitude[30] ? (~req_bus.latitude + 31'd1)
                                         : req_bus.latitude;

   always_comb begin
      item0_in         = '0;
      item0_in.a       = (lon_abs > PI_Q) ? PI_Q[30:0] : lon_abs[30:0];
      item0_in.p       = (lat_abs > {1'b0, HALF_Q}) ? HALF_Q : lat_abs[29:0];
      item0_in.lon_neg = req_bus.longitude[31];
      item0_in.lat_neg = req_bus.latitude[30];
      item0_in.sine    = sine_latitude_ff;
      // arc formula only for the outer part of the map
      item0_in.oval    = oval_outer_ff && (item0_in.a >= {1'b0, HALF_Q});
   end

   // ---------------------------------------------------------------- stage 1: z = p^2
   logic [59:0]  pp0_prod;
   logic [30:0]  z1_ff, z1_in;
   gpf_item_type item1_ff;
   logic         v1_ff;

   assign pp0_prod = item0_ff.p * item0_ff.p;
   assign z1_in    = pp0_prod[FRAC_BITS+30:FRAC_BITS];

   // ---------------------------------------------------------------- sine horner chain
   logic         sn_valid [SINE_TERMS+1];
   logic [30:0]  sn_z     [SINE_TERMS+1];
   logic [29:0]  sn_t     [SINE_TERMS+1];
   gpf_item_type sn_item  [SINE_TERMS+1];

   assign sn_valid[0] = v1_ff;
   assign sn_z[0]     = z1_ff;
   assign sn_t[0]     = ONE_Q;
   assign sn_item[0]  = item1_ff;

   for (genvar i = 0; i < SINE_TERMS; i++) begin : g_sine
      gpf_sine_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sn_valid[i]),
         .in_z      (sn_z[i]),
         .in_t      (sn_t[i]),
         .in_item   (sn_item[i]),
         .div_k     (SINE_DIV[i]),
         .recip_k   (SINE_RECIP[i]),
         .out_valid (sn_valid[i+1]),
         .out_z     (sn_z[i+1]),
         .out_t     (sn_t[i+1]),
         .out_item  (sn_item[i+1])
      );
   end

   // ---------------------------------------------------------------- stage 2: sin = p*t
   logic [59:0]  sin_prod;
   logic [29:0]  sin2_ff, sin2_in;
   gpf_item_type item2_ff;
   logic         v2_ff;

   assign sin_prod = sn_item[SINE_TERMS].p * sn_t[SINE_TERMS];
   assign sin2_in  = sin_prod[FRAC_BITS+29:FRAC_BITS];

   // ---------------------------------------------------------------- stage 3: pick northing
   logic [59:0]  vs_prod;
   gpf_item_type item3_ff, item3_in;
   logic         v3_ff;

   assign vs_prod = HALF_Q * sin2_ff;

   always_comb begin
      item3_in   = item2_ff;
      item3_in.v = item2_ff.sine ? vs_prod[FRAC_BITS+29:FRAC_BITS] : item2_ff.p;
   end

   // ---------------------------------------------------------------- stage 4: products
   logic [61:0]  fa_prod;
   logic [60:0]  fav_prod;
   logic [59:0]  fvv_prod;
   logic [32:0]  fa4_ff, fa4_in;
   logic [31:0]  fav4_ff, fav4_in;
   logic [30:0]  fvv4_ff, fvv4_in;
   logic [59:0]  pp4_ff, pp4_in;
   gpf_item_type item4_ff;
   logic         v4_ff;

   assign fa_prod  = item3_ff.a * item3_ff.a;
   assign fav_prod = item3_ff.a * item3_ff.v;
   assign fvv_prod = item3_ff.v * item3_ff.v;
   assign fa4_in   = fa_prod[FRAC_BITS+32:FRAC_BITS];
   assign fav4_in  = fav_prod[FRAC_BITS+31:FRAC_BITS];
   assign fvv4_in  = fvv_prod[FRAC_BITS+30:FRAC_BITS];
   assign pp4_in   = item3_ff.p * item3_ff.p;

   // ---------------------------------------------------------------- stage 5: g, 2m, numerator
   logic [59:0]  hsq_wide;
   logic [32:0]  m2_5_ff, m2_5_in;
   logic [59:0]  ro5_ff, ro5_in;
   gpf_item_type item5_ff, item5_in;
   logic         v5_ff;

   assign hsq_wide = {HSQ_Q, {FRAC_BITS{1'b0}}};
   assign m2_5_in  = {fav4_ff, 1'b0};
   // arc radicand hsq - p^2, clamped at zero
   assign ro5_in   = (hsq_wide >= pp4_ff) ? (hsq_wide - pp4_ff) : '0;

   always_comb begin
      item5_in    = item4_ff;
      item5_in.g  = {3'b000, HSQ_Q} + {1'b0, fa4_ff};
      item5_in.nq = {item4_ff.a, 1'b0} * fvv4_ff;
   end

   // ---------------------------------------------------------------- stage 6: squares
   logic [67:0]  gg6_ff, gg6_in;
   logic [65:0]  mm6_ff, mm6_in;
   logic [59:0]  ro6_ff;
   gpf_item_type item6_ff;
   logic         v6_ff;

   assign gg6_in = item5_ff.g * item5_ff.g;
   assign mm6_in = m2_5_ff * m2_5_ff;

   // ---------------------------------------------------------------- stage 7: radicand
   logic [67:0]  gm_diff;
   logic [65:0]  rad7_ff, rad7_in;
   gpf_item_type item7_ff;
   logic         v7_ff;

   assign gm_diff = gg6_ff - {2'b00, mm6_ff};
   assign rad7_in = item6_ff.oval ? {6'd0, ro6_ff}
                  : ((gg6_ff >= {2'b00, mm6_ff}) ? gm_diff[65:0] : '0);

   // ---------------------------------------------------------------- square root chain
   logic         sq_valid [SQRT_STEPS+1];
   logic [65:0]  sq_rad   [SQRT_STEPS+1];
   logic [34:0]  sq_rem   [SQRT_STEPS+1];
   logic [32:0]  sq_root  [SQRT_STEPS+1];
   gpf_item_type sq_item  [SQRT_STEPS+1];

   assign sq_valid[0] = v7_ff;
   assign sq_rad[0]   = rad7_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_item[0]  = item7_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      gpf_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[i]),
         .in_rad    (sq_rad[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_item   (sq_item[i]),
         .out_valid (sq_valid[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_item  (sq_item[i+1])
      );
   end

   // ---------------------------------------------------------------- stage 8: divisor g + r
   logic [62:0]  num8;
   logic [33:0]  drem8_ff, drem8_in;
   logic [31:0]  dnum8_ff, dnum8_in;
   gpf_item_type item8_ff, item8_in;
   logic         v8_ff;

   // arc points skip the bulge, a zero numerator keeps the chain harmless
   assign num8     = sq_item[SQRT_STEPS].oval ? '0 : sq_item[SQRT_STEPS].nq;
   assign drem8_in = {3'b000, num8[62:32]};
   assign dnum8_in = num8[31:0];

   always_comb begin
      item8_in      = sq_item[SQRT_STEPS];
      item8_in.root = sq_root[SQRT_STEPS];
      item8_in.g    = sq_item[SQRT_STEPS].g + {1'b0, sq_root[SQRT_STEPS]};
   end

   // ---------------------------------------------------------------- divide chain
   logic         dv_valid [DIV_STEPS+1];
   logic [33:0]  dv_rem   [DIV_STEPS+1];
   logic [31:0]  dv_num   [DIV_STEPS+1];
   logic [31:0]  dv_quo   [DIV_STEPS+1];
   gpf_item_type dv_item  [DIV_STEPS+1];

   assign dv_valid[0] = v8_ff;
   assign dv_rem[0]   = drem8_ff;
   assign dv_num[0]   = dnum8_ff;
   assign dv_quo[0]   = '0;
   assign dv_item[0]  = item8_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      gpf_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[i]),
         .in_rem    (dv_rem[i]),
         .in_num    (dv_num[i]),
         .in_quo    (dv_quo[i]),
         .in_item   (dv_item[i]),
         .out_valid (dv_valid[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_num   (dv_num[i+1]),
         .out_quo   (dv_quo[i+1]),
         .out_item  (dv_item[i+1])
      );
   end

   // ---------------------------------------------------------------- final easting
   gpf_item_type     fin;
   logic [31:0]      quo;
   logic [33:0]      oval_x;
   logic [31:0]      glob_x;
   logic [31:0]      x_mag;
   logic [31:0]      push_x;
   logic [30:0]      push_y;
   logic             push;

   assign fin    = dv_item[DIV_STEPS];
   assign quo    = dv_quo[DIV_STEPS];
   assign oval_x = {1'b0, fin.root} + {3'b000, fin.a} - {4'b0000, HALF_Q};
   // bulge pulls x toward zero, never past it
   assign glob_x = (quo >= {1'b0, fin.a}) ? '0 : ({1'b0, fin.a} - quo);
   assign x_mag  = (fin.a == '0) ? '0 : (fin.oval ? oval_x[31:0] : glob_x);
   assign push_x = fin.lon_neg ? (~x_mag + 32'd1) : x_mag;
   assign push_y = fin.lat_neg ? (~{1'b0, fin.v} + 31'd1) : {1'b0, fin.v};
   assign push   = dv_valid[DIV_STEPS] && en;

   // ---------------------------------------------------------------- stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_bus.valid;
         v1_ff <= v0_ff;
         v2_ff <= sn_valid[SINE_TERMS];
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= sq_valid[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item0_ff <= item0_in;
         z1_ff    <= z1_in;
         item1_ff <= item0_ff;
         sin2_ff  <= sin2_in;
         item2_ff <= sn_item[SINE_TERMS];
         item3_ff <= item3_in;
         fa4_ff   <= fa4_in;
         fav4_ff  <= fav4_in;
         fvv4_ff  <= fvv4_in;
         pp4_ff   <= pp4_in;
         item4_ff <= item3_ff;
         m2_5_ff  <= m2_5_in;
         ro5_ff   <= ro5_in;
         item5_ff <= item5_in;
         gg6_ff   <= gg6_in;
         mm6_ff   <= mm6_in;
         ro6_ff   <= ro5_ff;
         item6_ff <= item5_ff;
         rad7_ff  <= rad7_in;
         item7_ff <= item6_ff;
         drem8_ff <= drem8_in;
         dnum8_ff <= dnum8_in;
         item8_ff <= item8_in;
      end
   end

   // ---------------------------------------------------------------- output buffer
   logic [31:0] bx0_ff, bx0_in, bx1_ff, bx1_in;
   logic [30:0] by0_ff, by0_in, by1_ff, by1_in;
   logic        pop;

   assign pop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      bx0_in   = bx0_ff;
      by0_in   = by0_ff;
      bx1_in   = bx1_ff;
      by1_in   = by1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               bx0_in = push_x;
               by0_in = push_y;
            end else begin
               bx1_in = push_x;
               by1_in = push_y;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            bx0_in   = bx1_ff;
            by0_in   = by1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            // one leaves, one arrives: count holds
            if (count_ff == 2'd1) begin
               bx0_in = push_x;
               by0_in = push_y;
            end else begin
               bx0_in = bx1_ff;
               by0_in = by1_ff;
               bx1_in = push_x;
               by1_in = push_y;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bx0_ff <= bx0_in;
      by0_ff <= by0_in;
      bx1_ff <= bx1_in;
      by1_ff <= by1_in;
   end

   assign rsp_bus.valid   = (count_ff != 2'd0);
   assign rsp_bus.plane_x = bx0_ff;
   assign rsp_bus.plane_y = by0_ff;

   // ---------------------------------------------------------------- checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer holds more than two responses");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 2'd1 ||
                count_ff == $past(count_ff) - 2'd1))
      else $error("output buffer count jumped");

   a_y_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ($signed(rsp_bus.plane_y) <= $signed({1'b0, HALF_Q}) &&
                         $signed(rsp_bus.plane_y) >= -$signed({1'b0, HALF_Q})))
      else $error("northing beyond half pi");

   a_x_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ($signed(rsp_bus.plane_x) <= $signed(PI_Q) &&
                         $signed(rsp_bus.plane_x) >= -$signed(PI_Q)))
      else $error("easting beyond pi");

endmodule

`default_nettype wire

// ----- test/tb_globular_projection_forward.sv -----
// testbench for the globular projection: checks every response against a bit-exact predictor
`default_nettype none

module tb_globular_projection_forward import gpf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 99;
   localparam longint PI_LIM   = 1686629713;
   localparam longint HALF_LIM = 843314857;

   typedef struct {
      logic signed [31:0] plane_x;
      logic signed [30:0] plane_y;
   } plane_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gpf_req_if req_bus ();
   gpf_rsp_if rsp_bus ();
   gpf_csr_if csr_bus ();

   globular_projection_forward dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always #5 clock = ~clock;

   // predictor copy of the mode registers
   logic bacon_mode = 1'b0;
   logic oval_mode  = 1'b0;

   plane_point_type expected_points [$];
   int  error_count = 0;
   bit  quiet_mode  = 1'b0;   // no random idling on either side
   int  hold_cycles = 0;      // long receiver hold-off when nonzero

   // floor(n / d) over 128 bits, saturating on a zero divisor
   function automatic logic [63:0] div_floor(logic [127:0] n, logic [63:0] d);
      if (d == 0) begin
         return '1;
      end
      return 64'(n / d);
   endfunction

   function automatic logic [63:0] isqrt_floor(logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  t;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (128'(t) * 128'(t) <= n) begin
            r = t;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
      return 64'((128'(a) * 128'(b)) >> FRAC_BITS);
   endfunction

   function automatic logic [127:0] sub_floor0(logic [127:0] a, logic [127:0] b);
      return (b > a) ? 128'd0 : a - b;
   endfunction

   function automatic plane_point_type project_point(logic signed [31:0] lon_in,
                                                     logic signed [30:0] lat_in);
      plane_point_type res;
      longint lon, lat, xs, ys;
      logic [63:0] one, half, hsq, a, p, v, x, z, t, g, m2, r, qt;
      one  = 64'd1 << FRAC_BITS;
      half = 64'(HALF_Q);
      hsq  = 64'(HSQ_Q);
      lon  = longint'(lon_in);
      lat  = longint'(lat_in);
      if (lon > PI_LIM) lon = PI_LIM;
      if (lon < -PI_LIM) lon = -PI_LIM;
      if (lat > HALF_LIM) lat = HALF_LIM;
      if (lat < -HALF_LIM) lat = -HALF_LIM;
      a = (lon < 0) ? 64'(-lon) : 64'(lon);
      p = (lat < 0) ? 64'(-lat) : 64'(lat);
      x = 0;
      if (bacon_mode) begin
         // nested horner form of the sine series, top term first
         z = fix_mul(p, p);
         t = one;
         for (int k = 8; k >= 1; k--) begin
            t = one - div_floor(128'(z) * 128'(t), 64'((2 * k) * (2 * k + 1)) * one);
         end
         v = fix_mul(half, fix_mul(p, t));
      end else begin
         v = p;
      end
      if (a != 0) begin
         if (oval_mode && a >= half) begin
            // ortelius circular arc outside the central hemisphere
            x = isqrt_floor(sub_floor0(128'(hsq) * 128'(one), 128'(p) * 128'(p))) + a - half;
         end else begin
            // bulge term written as a - 2a*v^2/(g + root) to avoid cancellation
            g  = hsq + fix_mul(a, a);
            m2 = 2 * fix_mul(a, v);
            r  = isqrt_floor(sub_floor0(128'(g) * 128'(g), 128'(m2) * 128'(m2)));
            qt = div_floor(128'(2 * a) * 128'(fix_mul(v, v)), g + r);
            x  = (qt >= a) ? 64'd0 : a - qt;
         end
      end
      if (x > 64'h8000_0000) x = 64'h8000_0000;
      xs = (lon < 0) ? -longint'(x) : longint'(x);
      if (xs > 64'sh7FFF_FFFF) xs = 64'sh7FFF_FFFF;
      if (v > 64'h4000_0000) v = 64'h4000_0000;
      ys = (lat < 0) ? -longint'(v) : longint'(v);
      if (ys > 64'sh3FFF_FFFF) ys = 64'sh3FFF_FFFF;
      res.plane_x = xs[31:0];
      res.plane_y = ys[30:0];
      return res;
   endfunction

   // input side: one request, random idle before it unless quiet
   task automatic send_point(logic signed [31:0] lon, logic signed [30:0] lat);
      while (!quiet_mode && $urandom_range(99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.longitude <= lon;
      req_bus.latitude  <= lat;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      expected_points.push_back(project_point(lon, lat));
   endtask

   // valid stays high after the write; set_modes drops it
   task automatic write_mode(logic [1:0] index, logic value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      if (index == CSR_SINE_LATITUDE) bacon_mode = value;
      else if (index == CSR_OVAL_OUTER) oval_mode = value;
   endtask

   // wait for the pipeline to drain before touching the mode registers
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      while (expected_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_modes(logic bacon, logic oval);
      drain_pipeline();
      write_mode(CSR_SINE_LATITUDE, bacon);
      write_mode(CSR_OVAL_OUTER, oval);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_longitude();
      case ($urandom_range(9))
         0: return $urandom;                                   // any pattern, saturates
         1: return 32'($urandom_range(3)) - 32'sd1;            // near zero
         2: return 32'(HALF_LIM + longint'($urandom_range(20)) - 10);   // arc switch point
         3: return 32'(-(HALF_LIM + longint'($urandom_range(20)) - 10));
         default: return 32'(longint'($urandom_range(2 * PI_LIM)) - PI_LIM);
      endcase
   endfunction

   function automatic logic signed [30:0] random_latitude();
      case ($urandom_range(7))
         0: return 31'($urandom);
         1: return 31'($urandom_range(3)) - 31'sd1;
         default: return 31'(longint'($urandom_range(2 * HALF_LIM)) - HALF_LIM);
      endcase
   endfunction

   task automatic test_directed_extremes();
      logic signed [31:0] lons [8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 32'(PI_LIM),
                                       32'(-PI_LIM), 32'(HALF_LIM), 32'(-HALF_LIM),
                                       32'(HALF_LIM - 1)};
      logic signed [30:0] lats [5] = '{31'sh4000_0000, 31'sh3FFF_FFFF, 31'sd0,
                                       31'(HALF_LIM), 31'(-HALF_LIM)};
      for (int m = 0; m < 4; m++) begin
         set_modes(m[0], m[1]);
         foreach (lons[i]) send_point(lons[i], lats[i % 5]);
         send_point(32'sd1, 31'sd1);
         send_point(-32'sd1, 31'sh4000_0000);
      end
   endtask

   task automatic test_random_modes();
      for (int phase = 0; phase < 8; phase++) begin
         set_modes(1'($urandom_range(1)), 1'($urandom_range(1)));
         quiet_mode = (phase == 3);   // one stretch without any idling
         repeat (220) send_point(random_longitude(), random_latitude());
      end
      quiet_mode = 1'b0;
   endtask

   task automatic test_output_backpressure();
      set_modes(1'b1, 1'b1);
      hold_cycles = 300;              // receiver stalls while requests keep coming
      quiet_mode  = 1'b1;
      repeat (150) send_point(random_longitude(), random_latitude());
      quiet_mode  = 1'b0;
      set_modes(1'b0, 1'b0);
      repeat (50) send_point(random_longitude(), random_latitude());
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_bus.ready <= quiet_mode || ($urandom_range(99) >= 14);
         end
      end
   end

   // response checker, sampled at the edge where the response is taken
   always @(posedge clock) begin
      plane_point_type exp_pt;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_points.size() == 0) begin
            $error("response with nothing expected: x=%0d y=%0d",
                   rsp_bus.plane_x, rsp_bus.plane_y);
            error_count++;
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_bus.plane_x !== exp_pt.plane_x) begin
               $error("plane_x expected %0d actual %0d", exp_pt.plane_x, rsp_bus.plane_x);
               error_count++;
            end
            if (rsp_bus.plane_y !== exp_pt.plane_y) begin
               $error("plane_y expected %0d actual %0d", exp_pt.plane_y, rsp_bus.plane_y);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.longitude = '0;
      req_bus.latitude  = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_random_modes();
      test_output_backpressure();
      drain_pipeline();
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
